[rtl/core/aarm_pkg.sv]
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared constants, tables and types of the axis-angle rotation matrix block.
// ----------------------------------------------------------------------------
package aarm_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int FRAC_BITS_DEF    = 14;

	localparam logic signed [15:0] ANGLE_LIMIT = 16'sd25736;
	localparam logic signed [15:0] ONE_Q14     = 16'sd16384;

	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] GAIN_Q30    = 64'd652032874;

	localparam int ATAN_ENTRIES = 24;
	localparam int STEP_W       = $clog2(ATAN_ENTRIES);

	localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
		32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
		32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
		32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
		32'd262143,    32'd131071,    32'd65535,     32'd32767,
		32'd16383,     32'd8191,      32'd4095,      32'd2047,
		32'd1023,      32'd511,       32'd255,       32'd127
	};

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_PREP,
		EM_EMIT
	} emit_state_t;

endpackage

[rtl/core/aarm_front.sv]
// ----------------------------------------------------------------------------
// aarm_front
// Clamps the angle, brings it to the working format, folds it into
// [-pi/2, pi/2] and flags a zero axis.
// ----------------------------------------------------------------------------
module aarm_front #(
	parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
	input  logic signed [15:0]          angle,
	input  logic signed [15:0]          axis_x,
	input  logic signed [15:0]          axis_y,
	input  logic signed [15:0]          axis_z,
	output logic signed [FRAC_BITS+2:0] z,
	output logic                        neg,
	output logic                        zero_axis
);

	localparam int CW   = FRAC_BITS + 3;
	localparam int SH_L = (FRAC_BITS >= 13) ? FRAC_BITS - 13 : 0;
	localparam int SH_R = (FRAC_BITS >= 13) ? 0 : 13 - FRAC_BITS;
	localparam logic signed [CW-1:0] PI_W   = CW'(aarm_pkg::PI_Q30 >> (30 - FRAC_BITS));
	localparam logic signed [CW-1:0] HALF_W = CW'(aarm_pkg::HALF_PI_Q30 >> (30 - FRAC_BITS));

	logic signed [15:0]   ang_c;
	logic signed [CW-1:0] z0;

	always_comb begin
		if (angle > aarm_pkg::ANGLE_LIMIT) begin
			ang_c = aarm_pkg::ANGLE_LIMIT;
		end else if (angle < -aarm_pkg::ANGLE_LIMIT) begin
			ang_c = -aarm_pkg::ANGLE_LIMIT;
		end else begin
			ang_c = angle;
		end
		z0 = (CW'(ang_c) <<< SH_L) >>> SH_R;
		// fold into the right half plane, negate sin and cos later
		if (z0 > HALF_W) begin
			z   = z0 - PI_W;
			neg = 1'b1;
		end else if (z0 < -HALF_W) begin
			z   = z0 + PI_W;
			neg = 1'b1;
		end else begin
			z   = z0;
			neg = 1'b0;
		end
	end

	assign zero_axis = (axis_x == 16'sd0) && (axis_y == 16'sd0) && (axis_z == 16'sd0);

endmodule

[rtl/core/aarm_queue.sv]
// ----------------------------------------------------------------------------
// aarm_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module aarm_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output logic          not_empty
);

	logic [DW-1:0] mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	assign rdata     = mem_q[rd_q];
	assign full      = cnt_q[1];
	assign not_empty = (cnt_q != 2'd0);

endmodule

[rtl/core/aarm_cordic.sv]
// ----------------------------------------------------------------------------
// aarm_cordic
// Iterative rotation-mode CORDIC, one step per cycle, giving cos and sin.
// ----------------------------------------------------------------------------
module aarm_cordic #(
	parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF,
	parameter int FRAC_BITS    = aarm_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic signed [FRAC_BITS+2:0] req_z,
	input  logic                        req_neg,
	input  logic signed [15:0]          req_ax,
	input  logic signed [15:0]          req_ay,
	input  logic signed [15:0]          req_az,
	input  logic                        req_zero,
	output logic                        req_take,
	output logic                        res_valid,
	output logic signed [FRAC_BITS+2:0] res_c,
	output logic signed [FRAC_BITS+2:0] res_s,
	output logic signed [15:0]          res_ax,
	output logic signed [15:0]          res_ay,
	output logic signed [15:0]          res_az,
	output logic                        res_zero,
	input  logic                        res_take
);

	localparam int CW = FRAC_BITS + 3;
	localparam int N  = (CORDIC_STEPS < aarm_pkg::ATAN_ENTRIES) ?
		CORDIC_STEPS : aarm_pkg::ATAN_ENTRIES;
	localparam logic signed [CW-1:0] GAIN_W =
		CW'(aarm_pkg::GAIN_Q30 >> (30 - FRAC_BITS));

	logic                       busy_q;
	logic                       done_q;
	logic [aarm_pkg::STEP_W-1:0] i_q;
	logic signed [CW-1:0]       x_q, y_q, z_q;
	logic                       neg_q, zero_q;
	logic signed [15:0]         ax_q, ay_q, az_q;

	logic signed [CW-1:0] dx, dy, da, xn, yn, zn;
	logic                 last_step;

	always_comb begin
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		da = CW'(aarm_pkg::ATAN_Q30[i_q] >> (30 - FRAC_BITS));
		if (!z_q[CW-1]) begin
			xn = x_q - dx;
			yn = y_q + dy;
			zn = z_q - da;
		end else begin
			xn = x_q + dx;
			yn = y_q - dy;
			zn = z_q + da;
		end
	end

	assign last_step = (i_q == aarm_pkg::STEP_W'(N - 1));
	assign req_take  = req_valid && !busy_q && (!done_q || res_take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			if (req_take) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (res_take) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			x_q    <= GAIN_W;
			y_q    <= '0;
			z_q    <= req_z;
			neg_q  <= req_neg;
			ax_q   <= req_ax;
			ay_q   <= req_ay;
			az_q   <= req_az;
			zero_q <= req_zero;
		end else if (busy_q) begin
			z_q <= zn;
			// apply the half-turn fold on the final step
			if (last_step && neg_q) begin
				x_q <= -xn;
				y_q <= -yn;
			end else begin
				x_q <= xn;
				y_q <= yn;
			end
		end
	end

	assign res_valid = done_q;
	assign res_c     = x_q;
	assign res_s     = y_q;
	assign res_ax    = ax_q;
	assign res_ay    = ay_q;
	assign res_az    = az_q;
	assign res_zero  = zero_q;

endmodule

[rtl/core/aarm_emit.sv]
// ----------------------------------------------------------------------------
// aarm_emit
// Builds the matrix from cos, sin and the axis and sends one element a cycle while out_stall is low.
// ----------------------------------------------------------------------------
module aarm_emit #(
	parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        res_valid,
	input  logic signed [FRAC_BITS+2:0] res_c,
	input  logic signed [FRAC_BITS+2:0] res_s,
	input  logic signed [15:0]          res_ax,
	input  logic signed [15:0]          res_ay,
	input  logic signed [15:0]          res_az,
	input  logic                        res_zero,
	output logic                        res_take,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  row_index,
	output logic [1:0]                  col_index,
	output logic signed [15:0]          element,
	output logic                        last_element
);

	localparam int EW  = FRAC_BITS + 6;
	localparam int RW  = EW + 8;
	localparam int SR  = (FRAC_BITS > 14) ? FRAC_BITS - 14 : 0;
	localparam int SL  = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
	localparam int RSH = (FRAC_BITS > 14) ? FRAC_BITS - 15 : 0;
	localparam logic signed [RW-1:0] RND = (FRAC_BITS > 14) ? (RW'(1) <<< RSH) : '0;
	localparam logic signed [EW-1:0] ONE_W = EW'(1) <<< FRAC_BITS;

	aarm_pkg::emit_state_t state_q, state_d;

	logic signed [EW-1:0] c_q, s_q, tx_q, ty_q, tz_q;
	logic signed [15:0]   ax_q, ay_q, az_q;
	logic                 zero_q;
	logic [3:0]           k_q;
	logic                 out_valid_q;
	logic                 advance, emit_go;

	logic signed [EW-1:0]    t;
	logic signed [EW+15:0]   ptx, pty, ptz, prod1, prod2;
	logic signed [EW-1:0]    ta, p1, p2, sum;
	logic signed [15:0]      ab, sa;
	logic                    add_s, sub_s, add_c, fixed;
	logic signed [15:0]      fixed_v;
	logic signed [RW-1:0]    r;
	logic signed [15:0]      elem_v;

	assign advance = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aarm_pkg::EM_IDLE: if (res_valid) state_d = aarm_pkg::EM_PREP;
			aarm_pkg::EM_PREP: state_d = aarm_pkg::EM_EMIT;
			aarm_pkg::EM_EMIT: if (advance && k_q == 4'd15) state_d = aarm_pkg::EM_IDLE;
			default:           state_d = aarm_pkg::EM_IDLE;
		endcase
	end

	always_comb begin
		res_take = 1'b0;
		emit_go  = 1'b0;
		unique case (state_q)
			aarm_pkg::EM_IDLE: res_take = res_valid;
			aarm_pkg::EM_PREP: ;
			aarm_pkg::EM_EMIT: emit_go = advance;
			default:           ;
		endcase
	end

	// t*a products for the symmetric part
	always_comb begin
		t   = ONE_W - EW'(c_q);
		ptx = t * ax_q;
		pty = t * ay_q;
		ptz = t * az_q;
	end

	always_comb begin
		ta      = tx_q;
		ab      = ax_q;
		sa      = ax_q;
		add_s   = 1'b0;
		sub_s   = 1'b0;
		add_c   = 1'b0;
		fixed   = 1'b0;
		fixed_v = '0;
		case (k_q) inside
			4'd0:  begin ta = tx_q; ab = ax_q; add_c = 1'b1; end
			4'd1:  begin ta = tx_q; ab = ay_q; sa = az_q; sub_s = 1'b1; end
			4'd2:  begin ta = tx_q; ab = az_q; sa = ay_q; add_s = 1'b1; end
			4'd4:  begin ta = tx_q; ab = ay_q; sa = az_q; add_s = 1'b1; end
			4'd5:  begin ta = ty_q; ab = ay_q; add_c = 1'b1; end
			4'd6:  begin ta = ty_q; ab = az_q; sa = ax_q; sub_s = 1'b1; end
			4'd8:  begin ta = tx_q; ab = az_q; sa = ay_q; sub_s = 1'b1; end
			4'd9:  begin ta = ty_q; ab = az_q; sa = ax_q; add_s = 1'b1; end
			4'd10: begin ta = tz_q; ab = az_q; add_c = 1'b1; end
			4'd15: begin fixed = 1'b1; fixed_v = aarm_pkg::ONE_Q14; end
			default: fixed = 1'b1;
		endcase
		// zero axis: exact identity
		if (zero_q) begin
			fixed = 1'b1;
			if (k_q == 4'd0 || k_q == 4'd5 || k_q == 4'd10 || k_q == 4'd15) begin
				fixed_v = aarm_pkg::ONE_Q14;
			end else begin
				fixed_v = '0;
			end
		end
	end

	always_comb begin
		prod1 = ta * ab;
		prod2 = s_q * sa;
		p1    = EW'(prod1 >>> 14);
		p2    = EW'(prod2 >>> 14);
		sum   = p1;
		if (add_s) begin
			sum = sum + p2;
		end else if (sub_s) begin
			sum = sum - p2;
		end
		if (add_c) begin
			sum = sum + c_q;
		end
		r = ((RW'(sum) + RND) >>> SR) <<< SL;
		if (fixed) begin
			elem_v = fixed_v;
		end else if (r > RW'(32767)) begin
			elem_v = 16'sh7fff;
		end else if (r < -RW'(32768)) begin
			elem_v = 16'sh8000;
		end else begin
			elem_v = r[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aarm_pkg::EM_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_take) begin
				k_q <= '0;
			end else if (emit_go) begin
				k_q <= k_q + 4'd1;
			end
			if (advance) begin
				out_valid_q <= emit_go;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			c_q    <= EW'(res_c);
			s_q    <= EW'(res_s);
			ax_q   <= res_ax;
			ay_q   <= res_ay;
			az_q   <= res_az;
			zero_q <= res_zero;
		end
		if (state_q == aarm_pkg::EM_PREP) begin
			tx_q <= EW'(ptx >>> 14);
			ty_q <= EW'(pty >>> 14);
			tz_q <= EW'(ptz >>> 14);
		end
		if (emit_go) begin
			row_index    <= k_q[3:2];
			col_index    <= k_q[1:0];
			element      <= elem_v;
			last_element <= (k_q == 4'd15);
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/core/axis_angle_rotation_matrix.sv]
// An accepted request passes the queue, the CORDIC steps and the sequencer setup state before
//   its first element is valid. Throughput: one element per cycle while out_stall is low;
//   the iterative CORDIC and the sequencer (setup plus sixteen elements) set the matrix rate.
// The CORDIC of the next request runs while the current matrix streams out.
// Reset: arst_n clears the queue, sequencer and valid flags; data registers keep
//   their contents.
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// 4x4 homogeneous rotation matrix from angle and axis by Rodrigues' formula.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
	parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF,
	parameter int FRAC_BITS    = aarm_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] angle,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         row_index,
	output logic [1:0]         col_index,
	output logic signed [15:0] element,
	output logic               last_element
);

	localparam int CW = FRAC_BITS + 3;
	localparam int DW = CW + 50;

	logic signed [CW-1:0] f_z;
	logic                 f_neg, f_zero;
	logic                 q_full, q_ne, q_pop;
	logic [DW-1:0]        q_wdata, q_rdata;

	logic signed [CW-1:0] r_c, r_s;
	logic signed [15:0]   r_ax, r_ay, r_az;
	logic                 r_zero, r_valid, r_take;

	aarm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.z(f_z), .neg(f_neg), .zero_axis(f_zero)
	);

	assign q_wdata  = {f_z, f_neg, axis_x, axis_y, axis_z, f_zero};
	assign in_stall = q_full;

	aarm_queue #(.DW(DW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(in_valid && !q_full), .wdata(q_wdata), .full(q_full),
		.pop(q_pop), .rdata(q_rdata), .not_empty(q_ne)
	);

	aarm_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cordic (
		.clk(clk), .arst_n(arst_n),
		.req_valid(q_ne),
		.req_z(q_rdata[DW-1 -: CW]),
		.req_neg(q_rdata[49]),
		.req_ax(q_rdata[48:33]),
		.req_ay(q_rdata[32:17]),
		.req_az(q_rdata[16:1]),
		.req_zero(q_rdata[0]),
		.req_take(q_pop),
		.res_valid(r_valid), .res_c(r_c), .res_s(r_s),
		.res_ax(r_ax), .res_ay(r_ay), .res_az(r_az), .res_zero(r_zero),
		.res_take(r_take)
	);

	aarm_emit #(.FRAC_BITS(FRAC_BITS)) u_emit (
		.clk(clk), .arst_n(arst_n),
		.res_valid(r_valid), .res_c(r_c), .res_s(r_s),
		.res_ax(r_ax), .res_ay(r_ay), .res_az(r_az), .res_zero(r_zero),
		.res_take(r_take),
		.out_valid(out_valid), .out_stall(out_stall),
		.row_index(row_index), .col_index(col_index),
		.element(element), .last_element(last_element)
	);

endmodule

[rtl/core/aarm_checker.sv]
// ----------------------------------------------------------------------------
// aarm_checker
// Port-level checks of the rotation matrix block, bound to the top level.
// ----------------------------------------------------------------------------
module aarm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic signed [15:0] angle,
	input logic signed [15:0] axis_x,
	input logic signed [15:0] axis_y,
	input logic signed [15:0] axis_z,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         row_index,
	input logic [1:0]         col_index,
	input logic signed [15:0] element,
	input logic               last_element
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(element) && $stable(row_index)
			&& $stable(col_index))
		else $error("stalled element changed");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_element == (row_index == 2'd3 && col_index == 2'd3)))
		else $error("last flag not on final element");

	a_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_index == 2'd3 && col_index != 2'd3 |-> element == 16'sd0)
		else $error("bottom row not zero");

	a_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_element |-> element == 16'sd16384)
		else $error("corner element not one");

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (.*);

[tb/axis_angle_rotation_matrix_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_checker
// Watches both channels, computes the expected rotation matrix of every
// accepted request and compares each streamed element against it.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_checker #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] angle,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         row_index,
	input  logic [1:0]         col_index,
	input  logic signed [15:0] element,
	input  logic               last_element,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [15:0] value;
		logic               last;
	} matrix_elem_t;

	matrix_elem_t elem_q[$];
	int           fail_cnt = 0;

	function automatic longint shr_floor(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint q30_to_w(longint v);
		return shr_floor(v, 30 - FRAC_BITS);
	endfunction

	function automatic longint round_sat14(longint v);
		longint r;
		if (FRAC_BITS > 14)
			r = shr_floor(v + (longint'(1) << (FRAC_BITS - 15)), FRAC_BITS - 14);
		else
			r = v * (longint'(1) << (14 - FRAC_BITS));
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r;
	endfunction

	function automatic longint mul_q14(longint w, longint a);
		return shr_floor(w * a, 14);
	endfunction

	task automatic rotation_matrix(input logic signed [15:0] ang,
			input logic signed [15:0] ax_in, ay_in, az_in);
		longint m[16];
		longint ax, ay, az, z, x, y, dx, dy, c, s, t, tx, ty, tz, pi_w, half_w;
		bit flip;
		matrix_elem_t e;
		ax = ax_in;
		ay = ay_in;
		az = az_in;
		flip = 0;
		for (int k = 0; k < 16; k++)
			m[k] = 0;
		if (ax == 0 && ay == 0 && az == 0) begin
			m[0] = aarm_pkg::ONE_Q14;
			m[5] = aarm_pkg::ONE_Q14;
			m[10] = aarm_pkg::ONE_Q14;
		end else begin
			z = ang;
			if (z > aarm_pkg::ANGLE_LIMIT)
				z = aarm_pkg::ANGLE_LIMIT;
			if (z < -aarm_pkg::ANGLE_LIMIT)
				z = -aarm_pkg::ANGLE_LIMIT;
			if (FRAC_BITS >= 13)
				z = z * (longint'(1) << (FRAC_BITS - 13));
			else
				z = shr_floor(z, 13 - FRAC_BITS);
			pi_w = q30_to_w(aarm_pkg::PI_Q30);
			half_w = q30_to_w(aarm_pkg::HALF_PI_Q30);
			// fold into the CORDIC's convergence range
			if (z > half_w) begin
				z -= pi_w;
				flip = 1;
			end else if (z < -half_w) begin
				z += pi_w;
				flip = 1;
			end
			x = q30_to_w(aarm_pkg::GAIN_Q30);
			y = 0;
			for (int i = 0; i < CORDIC_STEPS && i < aarm_pkg::ATAN_ENTRIES; i++) begin
				dx = shr_floor(y, i);
				dy = shr_floor(x, i);
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= q30_to_w(aarm_pkg::ATAN_Q30[i]);
				end else begin
					x += dx;
					y -= dy;
					z += q30_to_w(aarm_pkg::ATAN_Q30[i]);
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
			t = (longint'(1) << FRAC_BITS) - c;
			tx = mul_q14(t, ax);
			ty = mul_q14(t, ay);
			tz = mul_q14(t, az);
			m[0] = round_sat14(mul_q14(tx, ax) + c);
			m[1] = round_sat14(mul_q14(tx, ay) - mul_q14(s, az));
			m[2] = round_sat14(mul_q14(tx, az) + mul_q14(s, ay));
			m[4] = round_sat14(mul_q14(tx, ay) + mul_q14(s, az));
			m[5] = round_sat14(mul_q14(ty, ay) + c);
			m[6] = round_sat14(mul_q14(ty, az) - mul_q14(s, ax));
			m[8] = round_sat14(mul_q14(tx, az) - mul_q14(s, ay));
			m[9] = round_sat14(mul_q14(ty, az) + mul_q14(s, ax));
			m[10] = round_sat14(mul_q14(tz, az) + c);
		end
		m[15] = aarm_pkg::ONE_Q14;
		for (int k = 0; k < 16; k++) begin
			e.row = k[3:2];
			e.col = k[1:0];
			e.value = m[k][15:0];
			e.last = (k == 15);
			elem_q.push_back(e);
		end
	endtask

	task automatic report_mismatch(input string what);
		fail_cnt++;
		$display("%0t: element mismatch: %s", $time, what);
	endtask

	assign errors  = fail_cnt;
	assign pending = elem_q.size();

	always @(posedge clk) begin
		matrix_elem_t e;
		if (arst_n && in_valid && !in_stall)
			rotation_matrix(angle, axis_x, axis_y, axis_z);
		if (arst_n && out_valid && !out_stall) begin
			if (elem_q.size() == 0) begin
				report_mismatch("unexpected element");
			end else begin
				e = elem_q.pop_front();
				if (row_index !== e.row || col_index !== e.col || element !== e.value
						|| last_element !== e.last)
					report_mismatch($sformatf("got r%0d c%0d %0d l%0d, want r%0d c%0d %0d l%0d",
						row_index, col_index, element, last_element,
						e.row, e.col, e.value, e.last));
			end
		end
	end

endmodule

[tb/axis_angle_rotation_matrix_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_tb
// Drives directed and random angle/axis requests with random gaps and output
// stalls; the checker predicts each matrix and compares element by element.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_tb;
	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] angle;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         row_index;
	logic [1:0]         col_index;
	logic signed [15:0] element;
	logic               last_element;
	int                 errors;
	int                 pending;
	bit                 stim_done;

	axis_angle_rotation_matrix dut (.*);

	axis_angle_rotation_matrix_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	task automatic send_request(input logic signed [15:0] a, x, y, z);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		angle <= a;
		axis_x <= x;
		axis_y <= y;
		axis_z <= z;
		in_valid <= 1;
		// hold until accepted
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_range(int lo, int hi);
		return 16'(int'($urandom_range(0, hi - lo)) + lo);
	endfunction

	// output stall: random waits per element, with runs of none
	initial begin
		int wait_n;
		out_stall = 0;
		forever begin
			@(negedge clk);
			wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
			if (wait_n > 0) begin
				out_stall <= 1;
				repeat (wait_n) @(negedge clk);
				out_stall <= 0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	initial begin
		logic signed [15:0] a, x, y, z;
		int sel;
		arst_n = 0;
		in_valid = 0;
		angle = 0;
		axis_x = 0;
		axis_y = 0;
		axis_z = 0;
		stim_done = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: angle extremes, out-of-range clamp, folding, zero and non-unit axes
		send_request(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
		send_request(16'sd25736, 16'sd0, 16'sd16384, 16'sd0);
		send_request(-16'sd25736, 16'sd0, 16'sd0, 16'sd16384);
		send_request(16'sd32767, 16'sd9459, 16'sd9459, 16'sd9459);
		send_request(-16'sd32768, -16'sd9459, 16'sd9459, -16'sd9459);
		send_request(16'sd12868, 16'sd0, 16'sd0, -16'sd16384);
		send_request(16'sd12869, 16'sd16384, 16'sd0, 16'sd0);
		send_request(-16'sd12869, 16'sd0, -16'sd16384, 16'sd0);
		send_request(16'sd20000, 16'sd0, 16'sd0, 16'sd0);
		send_request(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);
		send_request(16'sd12868, -16'sd32768, -16'sd32768, -16'sd32768);
		send_request(-16'sd12868, 16'sd32767, 16'sd32767, 16'sd32767);
		send_request(16'sd25736, 16'sd32767, -16'sd32768, 16'sd32767);
		send_request(16'sd1, 16'sd16384, 16'sd16384, 16'sd0);
		send_request(-16'sd1, 16'sd0, 16'sd1, 16'sd0);
		for (int n = 0; n < 360; n++) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				a = rand_range(-25736, 25736);
				x = rand_range(-16384, 16384);
				y = rand_range(-16384, 16384);
				z = rand_range(-16384, 16384);
			end else if (sel < 8) begin
				a = 16'($urandom);
				x = 16'($urandom);
				y = 16'($urandom);
				z = 16'($urandom);
			end else if (sel == 8) begin
				a = 16'($urandom);
				x = 0;
				y = 0;
				z = 0;
			end else begin
				a = rand_range(-25736, 25736);
				x = 0;
				y = 0;
				z = 0;
				case ($urandom_range(0, 2))
					0: x = ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
					1: y = ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
					default: z = ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
				endcase
			end
			send_request(a, x, y, z);
		end
		in_valid <= 0;
		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
